[src/assert_macros.svh]
// Assertion macros used by the top level of the key matrix scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is disabled while reset is asserted.
`define ASSERT_CLKD(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[src/kmsd_pkg.sv]
// Package with the types, constants and helper functions of the key matrix scanner.
package kmsd_pkg;

    // Default number of matrix rows and reset value of the debounce register.
    localparam int          ROWS_DEFAULT   = 14;
    localparam logic [7:0]  DEBOUNCE_RESET = 8'd5;

    // Fixed field widths.
    localparam int ROW_IDX_W   = 4;
    localparam int PORT_W      = 8;
    localparam int KEY_W       = 6;
    localparam int KEYS_DOWN_W = 7;
    localparam int CNT_W       = 8;
    localparam int POP_W       = 3;

    // One result transaction as it leaves the matrix core.
    typedef struct packed {
        logic [KEY_W-1:0]       stable_row;
        logic                   settled;
        logic                   bounced;
        logic [KEYS_DOWN_W-1:0] keys_down;
    } result_t;

    // Active-low port bits 0,1,4,5,6,7 become key bits 0 to 5.
    function automatic logic [KEY_W-1:0] port_to_keys(input logic [PORT_W-1:0] port);
        port_to_keys = ~{port[7:4], port[1:0]};
    endfunction

    // Number of pressed keys in one row.
    function automatic logic [POP_W-1:0] popcount_row(input logic [KEY_W-1:0] keys);
        logic [POP_W-1:0] n;
        n = '0;
        for (int b = 0; b < KEY_W; b++) begin
            n = n + POP_W'(keys[b]);
        end
        popcount_row = n;
    endfunction

endpackage

[src/kmsd_core.sv]
// Matrix state, debounce countdown and result forming for one sampled row.
module kmsd_core #(
    parameter int ROWS = kmsd_pkg::ROWS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step_en,
    input  logic [kmsd_pkg::ROW_IDX_W-1:0]   row_index,
    input  logic [kmsd_pkg::PORT_W-1:0]      column_port,
    input  logic                             scan_end,
    input  logic                             cfg_wr_en,
    input  logic [kmsd_pkg::CNT_W-1:0]       cfg_wr_data,
    output kmsd_pkg::result_t                result
);

    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [kmsd_pkg::KEY_W-1:0]       working_reg [0:ROWS-1];
    logic [kmsd_pkg::KEY_W-1:0]       stable_reg  [0:ROWS-1];
    logic [kmsd_pkg::CNT_W-1:0]       quiet_reg;
    logic [kmsd_pkg::CNT_W-1:0]       debounce_reg;
    logic [kmsd_pkg::KEYS_DOWN_W-1:0] work_count_reg;
    logic [kmsd_pkg::KEYS_DOWN_W-1:0] stable_count_reg;

    logic [ROW_W-1:0]                 row_sel;
    logic                             in_range;
    logic [kmsd_pkg::KEY_W-1:0]       keys;
    logic [kmsd_pkg::KEY_W-1:0]       old_keys;
    logic                             changed;
    logic [kmsd_pkg::CNT_W-1:0]       quiet_loaded;
    logic                             count_down;
    logic [kmsd_pkg::CNT_W-1:0]       quiet_next;
    logic                             commit;
    logic [kmsd_pkg::KEYS_DOWN_W-1:0] work_count_next;
    logic [kmsd_pkg::KEYS_DOWN_W-1:0] stable_count_next;
    logic [kmsd_pkg::KEY_W-1:0]       row_out;

    // Sample compare, counter reload and end-of-scan countdown.
    always_comb begin
        row_sel      = row_index[ROW_W-1:0];
        in_range     = ({1'b0, row_index} < (kmsd_pkg::ROW_IDX_W + 1)'(ROWS));
        keys         = kmsd_pkg::port_to_keys(column_port);
        old_keys     = in_range ? working_reg[row_sel] : '0;
        changed      = in_range && (old_keys != keys);
        quiet_loaded = changed ? ((debounce_reg == '0) ? kmsd_pkg::CNT_W'(1) : debounce_reg)
                               : quiet_reg;
        count_down   = scan_end && (quiet_loaded != '0);
        quiet_next   = count_down ? (quiet_loaded - kmsd_pkg::CNT_W'(1)) : quiet_loaded;
        commit       = count_down && (quiet_next == '0);
    end

    // The working matrix count follows each row change, so a commit copies it.
    always_comb begin
        work_count_next = work_count_reg;
        if (changed) begin
            work_count_next = work_count_reg
                            - kmsd_pkg::KEYS_DOWN_W'(kmsd_pkg::popcount_row(old_keys))
                            + kmsd_pkg::KEYS_DOWN_W'(kmsd_pkg::popcount_row(keys));
        end
        stable_count_next = commit ? work_count_next : stable_count_reg;
    end

    // Stable bits of the sampled row as they stand after this step.
    always_comb begin
        if (!in_range) begin
            row_out = '0;
        end else if (commit) begin
            row_out = keys;
        end else begin
            row_out = stable_reg[row_sel];
        end
        result.stable_row = row_out;
        result.settled    = (quiet_next == '0);
        result.bounced    = changed && (quiet_reg != '0);
        result.keys_down  = stable_count_next;
    end

    // Matrix state and the debounce register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ROWS; i++) begin
                working_reg[i] <= '0;
                stable_reg[i]  <= '0;
            end
            quiet_reg        <= kmsd_pkg::DEBOUNCE_RESET;
            debounce_reg     <= kmsd_pkg::DEBOUNCE_RESET;
            work_count_reg   <= '0;
            stable_count_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                debounce_reg <= cfg_wr_data;
            end
            if (step_en) begin
                if (changed) begin
                    working_reg[row_sel] <= keys;
                end
                if (commit) begin
                    for (int i = 0; i < ROWS; i++) begin
                        stable_reg[i] <= (changed && (row_sel == ROW_W'(i))) ? keys
                                                                              : working_reg[i];
                    end
                end
                quiet_reg        <= quiet_next;
                work_count_reg   <= work_count_next;
                stable_count_reg <= stable_count_next;
            end
        end
    end

endmodule

[src/key_matrix_scan_debounce.sv]
// Top level of the key matrix scanner with debounce: handshake and result register.
//
//  Channel   Direction  Handshake           Payload
//  s_        in         s_valid / s_ready   s_row_index, s_column_port, s_scan_end
//  m_        out        m_valid / m_ready   m_stable_row, m_settled, m_bounced, m_keys_down
//  cfg_      in         cfg_wr_en           cfg_wr_data (debounce scans)
//
// One row transaction is accepted per cycle unless the output stalls; its result appears in
// the output register in the cycle after acceptance. The whole step, including the parallel
// commit of the matrix, is one combinational pass between the state and the result register.
// Reset is synchronous and active low; it clears both matrices and loads the counter.
// A stalled result holds the output register and the input side only while it is full.
module key_matrix_scan_debounce #(
    parameter int ROWS = kmsd_pkg::ROWS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [kmsd_pkg::ROW_IDX_W-1:0]     s_row_index,
    input  logic [kmsd_pkg::PORT_W-1:0]        s_column_port,
    input  logic                               s_scan_end,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [kmsd_pkg::KEY_W-1:0]         m_stable_row,
    output logic                               m_settled,
    output logic                               m_bounced,
    output logic [kmsd_pkg::KEYS_DOWN_W-1:0]   m_keys_down,
    input  logic                               cfg_wr_en,
    input  logic [kmsd_pkg::CNT_W-1:0]         cfg_wr_data
);

`include "assert_macros.svh"

    // Largest key count the matrix can hold.
    localparam logic [kmsd_pkg::KEYS_DOWN_W-1:0] KEYS_MAX =
        kmsd_pkg::KEYS_DOWN_W'(ROWS * kmsd_pkg::KEY_W);

    logic              m_valid_reg;
    kmsd_pkg::result_t result_reg;
    kmsd_pkg::result_t result_next;
    logic              in_fire;

    // The input side is open whenever the result register is empty or draining.
    assign s_ready = !m_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    kmsd_core #(
        .ROWS (ROWS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (in_fire),
        .row_index   (s_row_index),
        .column_port (s_column_port),
        .scan_end    (s_scan_end),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result      (result_next)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            result_reg <= result_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_stable_row = result_reg.stable_row;
    assign m_settled    = result_reg.settled;
    assign m_bounced    = result_reg.bounced;
    assign m_keys_down  = result_reg.keys_down;

    // Checks on the block's own logic.
    `ASSERT_CLKD(a_ready_when_empty, !m_valid_reg |-> s_ready, "input blocked with empty output")
    `ASSERT_CLKD(a_accept_gives_result, in_fire |=> m_valid_reg, "accepted row gave no result")
    `ASSERT_CLKD(a_keys_bound, m_valid_reg |-> (m_keys_down <= KEYS_MAX), "key count too large")

endmodule
